@@ rtl/apwh_pkg.sv @@
package apwh_pkg;

    // Default longest word; powers and the hash are taken modulo 2^(len+1)-1.
    localparam int MaxWordLenDef = 32;

    localparam int SumW    = 64;
    localparam int PosW    = 8;
    localparam int WordIdW = 33;

    localparam logic [PosW-1:0] AlphaLenRst = 8'd19;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

endpackage

@@ rtl/alphabet_polynomial_word_hash_top.sv @@
// Polynomial word hash over a loadable alphabet map. Load beats (tuser = 0) write the
// position of one byte value into a 256-entry map; word byte beats (tuser = 1) add
// position * base^index modulo M = 2^(MAX_WORD_LEN+1)-1 to a 64-bit wrapping sum, and the
// beat with tlast set returns sum mod M together with a flag that is set when the word
// had more than MAX_WORD_LEN bytes (the extra bytes are ignored). An empty-word beat
// (tuser = 2) returns 0 and drops any partly hashed word; tuser = 3 is ignored. The base
// is the alphabet length written on the configuration port, 19 after reset, and it may
// only be changed while no word is in flight. The block takes one beat in every cycle
// and each result passes through the registered map read, the multiply-accumulate and
// power update, and the final reduction modulo M. The whole pipeline stalls only while
// a result waits.
module alphabet_polynomial_word_hash_top #(
    parameter int MAX_WORD_LEN = apwh_pkg::MaxWordLenDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_value[7:0], position[15:8], position_present[16]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // word_id[32:0]
    output logic        m_axis_tuser    // too_long
);

    localparam int PW    = MAX_WORD_LEN + 1;
    localparam int IDXW  = $clog2(MAX_WORD_LEN + 1);
    localparam int PRW   = PW + apwh_pkg::PosW;
    localparam int SUMW  = apwh_pkg::SumW;
    localparam int NCH   = (SUMW + PW - 1) / PW;
    localparam int CSW   = PW + $clog2(NCH) + 1;
    localparam int NFOLD = (CSW - PW) / (PW - 1) + 2;
    localparam logic [PW-1:0] Mod = {PW{1'b1}};

    // Reduction modulo a Mersenne number: add the PW-bit chunks, fold the small carry
    // back in a few times, then one compare and subtract.
    function automatic logic [PW-1:0] mod_m(input logic [SUMW-1:0] v);
        logic [CSW-1:0] s;
        s = '0;
        for (int k = 0; k < NCH; k++) begin
            s = s + CSW'((v >> (k * PW)) & SUMW'(Mod));
        end
        for (int f = 0; f < NFOLD; f++) begin
            s = CSW'(s[PW-1:0]) + (s >> PW);
        end
        if (s >= CSW'(Mod)) begin
            s = s - CSW'(Mod);
        end
        return s[PW-1:0];
    endfunction

    logic                        en;
    logic                        in_acc;
    apwh_pkg::t_op               in_op;

    logic [8:0]                  r_map_mem [256];
    logic [255:0]                r_map_vld;
    logic [7:0]                  r_alpha;

    logic                        r_s1_vld;
    apwh_pkg::t_op               r_s1_op;
    logic                        r_s1_last;
    logic [8:0]                  r_s1_ent;
    logic                        r_s1_hit;

    logic [SUMW-1:0]             r_sum;
    logic [PW-1:0]               r_power;
    logic [IDXW-1:0]             r_idx;
    logic                        r_ovf;

    logic                        r_s2_vld;
    logic [SUMW-1:0]             r_s2_sum;
    logic                        r_s2_ovf;

    logic                        r_out_vld;
    logic [PW-1:0]               r_out_res;
    logic                        r_out_ovf;

    logic                        idx_ok;
    logic                        pos_ok;
    logic [PRW-1:0]              prod_pos;
    logic [PRW-1:0]              prod_base;
    logic [SUMW-1:0]             n_sum;
    logic [PW-1:0]               n_power;
    logic [IDXW-1:0]             n_idx;
    logic [SUMW-1:0]             out_wide;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;
    assign in_op         = apwh_pkg::t_op'(s_axis_tuser);

    // Map: written straight from the input beat, so a byte that follows a load of the
    // same value in the next cycle already sees the new entry.
    always_ff @(posedge i_clk) begin
        if (in_acc && in_op == apwh_pkg::OP_LOAD) begin
            r_map_mem[s_axis_tdata[7:0]] <= {s_axis_tdata[16], s_axis_tdata[15:8]};
        end
        if (in_acc) begin
            r_s1_ent  <= r_map_mem[s_axis_tdata[7:0]];
            r_s1_op   <= in_op;
            r_s1_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_alpha   <= apwh_pkg::AlphaLenRst;
            r_s1_vld  <= 1'b0;
            r_s1_hit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
            if (in_acc && in_op == apwh_pkg::OP_LOAD) begin
                r_map_vld[s_axis_tdata[7:0]] <= 1'b1;
            end
            if (en) begin
                r_s1_vld <= in_acc &&
                            (in_op == apwh_pkg::OP_BYTE || in_op == apwh_pkg::OP_EMPTY);
            end
            if (in_acc) begin
                r_s1_hit <= r_map_vld[s_axis_tdata[7:0]];
            end
        end
    end

    // Accumulate stage.
    assign idx_ok    = r_idx < IDXW'(MAX_WORD_LEN);
    assign pos_ok    = r_s1_hit && r_s1_ent[8] && idx_ok;
    assign prod_pos  = PRW'(r_power) * PRW'(r_s1_ent[7:0]);
    assign prod_base = PRW'(r_power) * PRW'(r_alpha);
    assign n_sum     = r_sum + (pos_ok ? SUMW'(prod_pos) : SUMW'(0));
    assign n_power   = mod_m(SUMW'(prod_base));
    assign n_idx     = r_idx + IDXW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_power  <= PW'(1);
            r_idx    <= '0;
            r_ovf    <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld &&
                        (r_s1_op == apwh_pkg::OP_EMPTY ||
                         (r_s1_op == apwh_pkg::OP_BYTE && r_s1_last));
            if (r_s1_vld) begin
                case (r_s1_op)
                    apwh_pkg::OP_EMPTY: begin
                        r_sum    <= '0;
                        r_power  <= PW'(1);
                        r_idx    <= '0;
                        r_ovf    <= 1'b0;
                    end
                    apwh_pkg::OP_BYTE: begin
                        if (r_s1_last) begin
                            r_sum    <= '0;
                            r_power  <= PW'(1);
                            r_idx    <= '0;
                            r_ovf    <= 1'b0;
                        end else if (idx_ok) begin
                            r_sum   <= n_sum;
                            r_power <= n_power;
                            r_idx   <= n_idx;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_vld) begin
            if (r_s1_op == apwh_pkg::OP_BYTE) begin
                r_s2_sum <= n_sum;
                r_s2_ovf <= r_ovf || !idx_ok;
            end else begin
                r_s2_sum <= '0;
                r_s2_ovf <= 1'b0;
            end
        end
    end

    // Final reduction and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_vld) begin
            r_out_res <= mod_m(r_s2_sum);
            r_out_ovf <= r_s2_ovf;
        end
    end

    assign out_wide      = SUMW'(r_out_res);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, out_wide[apwh_pkg::WordIdW-1:0]};
    assign m_axis_tuser  = r_out_ovf;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDXW'(MAX_WORD_LEN))
        else $error("byte index ran past the longest word");

    a_power_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power < Mod)
        else $error("running power not reduced modulo M");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_res < Mod)
        else $error("result not reduced modulo M");

    a_overflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_idx == IDXW'(MAX_WORD_LEN))
        else $error("overflow flagged before the word reached its length limit");

endmodule

@@ test/alphabet_polynomial_word_hash_top_tb.sv @@
`timescale 1ns / 100ps

module alphabet_polynomial_word_hash_top_tb;

    localparam logic [1:0]  OpIgnored  = 2'd3;
    localparam int          MaxLen     = apwh_pkg::MaxWordLenDef;
    localparam logic [63:0] HashMod    = (64'd1 << (MaxLen + 1)) - 64'd1;
    localparam int          IdlePct    = 26;
    localparam int          PhaseItems = 300;
    localparam int          DrainWait  = 8;
    localparam int          CycleLimit = 400000;

    typedef struct {
        logic [1:0]                op;
        logic [apwh_pkg::PosW-1:0] byte_val;
        logic [apwh_pkg::PosW-1:0] pos;
        logic                      present;
        logic                      last_byte;
    } t_beat;

    typedef struct {
        logic [apwh_pkg::WordIdW-1:0] word_id;
        logic                         too_long;
    } t_word_hash;

    typedef struct {
        t_beat      b;
        logic       typed;
        t_word_hash res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;   // byte_value[7:0], position[15:8], position_present[16]
    logic [1:0]  s_axis_tuser  = 2'd0;    // operation[1:0]
    logic        s_axis_tlast  = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // word_id[32:0]
    logic        m_axis_tuser;            // too_long

    alphabet_polynomial_word_hash_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Shadow state of the hasher.
    logic [8:0]                pos_map [256];
    logic [63:0]               word_sum;
    logic [63:0]               word_power;
    int                        word_len;
    logic                      long_seen;
    logic [apwh_pkg::PosW-1:0] alpha_len;

    t_word_hash expected_hashes[$];
    t_dir_row   dir_rows[$];
    logic [7:0] alpha_bytes[$];
    int         mismatches   = 0;
    int         items_sent   = 0;
    int         cycle_count  = 0;
    bit         src_gaps_on  = 1'b1;
    bit         sink_stall_on = 1'b1;

    task automatic report(input string msg);
        if (mismatches < 100)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_word();
        word_sum   = 64'd0;
        word_power = 64'd1;
        word_len   = 0;
        long_seen  = 1'b0;
    endfunction

    // Applies one accepted beat to the shadow state; returns 1 when it yields a hash.
    function automatic bit hash_accept(input t_beat b, output t_word_hash r);
        logic [8:0]  entry;
        logic [63:0] reduced;
        r = '{default: '0};
        if (b.op == apwh_pkg::OP_LOAD) begin
            pos_map[b.byte_val] = b.present ? {1'b1, b.pos} : 9'd0;
            return 1'b0;
        end
        if (b.op == apwh_pkg::OP_EMPTY) begin
            clear_word();
            return 1'b1;
        end
        if (b.op != apwh_pkg::OP_BYTE)
            return 1'b0;
        if (word_len < MaxLen) begin
            entry = pos_map[b.byte_val];
            if (entry[8])
                word_sum = word_sum + word_power * {56'd0, entry[7:0]};
            word_power = (word_power * {56'd0, alpha_len}) % HashMod;
            word_len++;
        end else begin
            long_seen = 1'b1;
        end
        if (b.last_byte) begin
            reduced    = word_sum % HashMod;
            r.word_id  = reduced[apwh_pkg::WordIdW-1:0];
            r.too_long = long_seen;
            clear_word();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_beat(input t_beat b, input bit typed, input t_word_hash typed_res);
        t_word_hash r;
        while (src_gaps_on && $urandom_range(0, 99) < IdlePct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, b.present, b.pos, b.byte_val};
        s_axis_tuser  <= b.op;
        s_axis_tlast  <= b.last_byte;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (hash_accept(b, r)) begin
            if (typed)
                r = typed_res;
            expected_hashes.insert(expected_hashes.size(), r);
        end
        if (b.op != OpIgnored)
            items_sent++;
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] bv, input logic [7:0] pos,
                        input logic present, input logic last_byte);
        t_beat b;
        b = '{op, bv, pos, present, last_byte};
        send_beat(b, 1'b0, '{default: '0});
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] bv, input logic [7:0] pos,
                           input logic present, input logic last_byte, input logic typed,
                           input logic [apwh_pkg::WordIdW-1:0] id, input logic too_long);
        t_dir_row row;
        row.b     = '{op, bv, pos, present, last_byte};
        row.typed = typed;
        row.res   = '{id, too_long};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // The base may only change with no word in flight and the pipeline drained.
    task automatic write_alpha_len(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        alpha_len = v;
    endtask

    task automatic load_alphabet(input int n);
        logic [7:0] bv;
        logic       present;
        for (int k = 0; k < n; k++) begin
            bv      = 8'($urandom_range(0, 255));
            present = ($urandom_range(0, 9) != 0);
            send(apwh_pkg::OP_LOAD, bv, 8'($urandom_range(0, 255)), present, 1'b0);
            if (present)
                alpha_bytes.insert(alpha_bytes.size(), bv);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if (alpha_bytes.size() != 0 && $urandom_range(0, 99) < 80)
            return alpha_bytes[$urandom_range(0, alpha_bytes.size() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 60)
            len = $urandom_range(1, 8);
        else if (r < 80)
            len = $urandom_range(9, MaxLen - 2);
        else if (r < 90)
            len = $urandom_range(MaxLen - 1, MaxLen + 1);
        else
            len = $urandom_range(MaxLen + 2, MaxLen + 13);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send(apwh_pkg::OP_LOAD, pick_byte(), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 11)
                send(OpIgnored, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 13) begin
                // Abandon the word part way through.
                send(apwh_pkg::OP_EMPTY, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                return;
            end
            send(apwh_pkg::OP_BYTE, pick_byte(), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), (k == len - 1));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_stall_on)
            m_axis_tready <= ($urandom_range(0, 99) >= IdlePct);
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin : check_results
        t_word_hash exp_hash;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_hashes.size() == 0) begin
                report($sformatf("unexpected word_id %0d",
                                 m_axis_tdata[apwh_pkg::WordIdW-1:0]));
            end else begin
                exp_hash = expected_hashes.pop_front();
                if (m_axis_tdata[apwh_pkg::WordIdW-1:0] !== exp_hash.word_id)
                    report($sformatf("word_id %0d, expected %0d",
                                     m_axis_tdata[apwh_pkg::WordIdW-1:0],
                                     exp_hash.word_id));
                if (m_axis_tuser !== exp_hash.too_long)
                    report($sformatf("too_long %b, expected %b",
                                     m_axis_tuser, exp_hash.too_long));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("alphabet_polynomial_word_hash_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] phase_len [6];
        for (int k = 0; k < 256; k++)
            pos_map[k] = 9'd0;
        alpha_len = apwh_pkg::AlphaLenRst;
        clear_word();

        // Directed rows; a nonzero typed flag carries a hash that is obvious by hand.
        add_row(apwh_pkg::OP_BYTE,  8'h61, 8'h00, 1'b0, 1'b1, 1'b1, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_EMPTY, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 33'd0,   1'b0);
        add_row(OpIgnored,          8'hff, 8'hff, 1'b1, 1'b1, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_LOAD,  8'h00, 8'hff, 1'b1, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_LOAD,  8'hff, 8'h00, 1'b1, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_LOAD,  8'h41, 8'h01, 1'b1, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 33'd255, 1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h41, 8'h00, 1'b0, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'hff, 8'h00, 1'b0, 1'b1, 1'b1, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h41, 8'h00, 1'b0, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_EMPTY, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_LOAD,  8'h41, 8'haa, 1'b0, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h41, 8'hff, 1'b1, 1'b1, 1'b1, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_LOAD,  8'h80, 8'h07, 1'b1, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h80, 8'h00, 1'b0, 1'b1, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 33'd0,   1'b0);
        add_row(OpIgnored,          8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 33'd0,   1'b0);
        add_row(apwh_pkg::OP_BYTE,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 33'd0,   1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_beat(dir_rows[k].b, dir_rows[k].typed, dir_rows[k].res);
        alpha_bytes.insert(alpha_bytes.size(), 8'h00);
        alpha_bytes.insert(alpha_bytes.size(), 8'h80);

        phase_len[0] = 8'd255;
        phase_len[1] = 8'd1;
        phase_len[2] = 8'd0;
        phase_len[3] = 8'($urandom_range(2, 254));
        phase_len[4] = apwh_pkg::AlphaLenRst;
        phase_len[5] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 6; p++) begin
            write_alpha_len(phase_len[p]);
            // One phase runs with both sides at full rate.
            src_gaps_on   = (p != 3);
            sink_stall_on = (p != 3);
            load_alphabet(24);
            while (items_sent < 20 + (p + 1) * PhaseItems)
                send_word();
            send(apwh_pkg::OP_EMPTY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0)
            @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0)
            $display("alphabet_polynomial_word_hash_top_tb: PASS");
        else
            $display("alphabet_polynomial_word_hash_top_tb: FAIL");
        $finish;
    end

endmodule
